// File: hw/rtl/fat_table_entry_engine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the FAT table entry engine
// Immediate-implication and next-cycle forms, sampled on clk and disabled
// while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FAT_TABLE_ENTRY_ENGINE_ASSERT_SVH
`define FAT_TABLE_ENTRY_ENGINE_ASSERT_SVH

`define FTE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define FTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/fte_pkg.sv
// ----------------------------------------------------------------------------
// FAT table entry engine package
// Store geometry, codes and shared types of the engine.
// ----------------------------------------------------------------------------
`default_nettype none

package fte_pkg;

  localparam int unsigned TABLE_BYTES = 16384;
  localparam int unsigned ADDR_W      = $clog2(TABLE_BYTES);
  localparam int unsigned LANES       = 4;
  localparam int unsigned LANE_W      = 2;
  localparam int unsigned BANK_AW     = ADDR_W - LANE_W;
  localparam int unsigned BANK_DEPTH  = TABLE_BYTES / LANES;

  localparam int unsigned OFF_W       = 30;
  localparam int unsigned ROOT_SECS_W = 14;
  localparam int unsigned SETTLE_W    = 3;
  localparam int unsigned GEO_SETTLE  = 5;

  localparam logic [31:0] FAT12_LIMIT = 32'd4085;
  localparam logic [31:0] FAT16_LIMIT = 32'd65525;
  localparam logic [27:0] EOC_FAT12   = 28'h0000FF8;
  localparam logic [27:0] EOC_FAT16   = 28'h000FFF8;
  localparam logic [27:0] EOC_FAT32   = 28'hFFFFFF8;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_READ     = 2'd1,
    OP_WRITE    = 2'd2,
    OP_READBACK = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_FAT12 = 2'd0,
    KIND_FAT16 = 2'd1,
    KIND_FAT32 = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    CFG_SECTOR_SIZE_LOG2  = 3'd0,
    CFG_CLUSTER_SIZE_LOG2 = 3'd1,
    CFG_RESERVED_SECTORS  = 3'd2,
    CFG_TABLE_COPIES      = 3'd3,
    CFG_SECTORS_PER_TABLE = 3'd4,
    CFG_ROOT_ENTRIES      = 3'd5,
    CFG_TOTAL_SECTORS     = 3'd6,
    CFG_ROOT_CLUSTER      = 3'd7
  } cfg_idx_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DATA = 1'b1
  } state_t;

  typedef struct packed {
    logic [3:0]  sector_log2;
    logic [2:0]  cluster_log2;
    logic [15:0] reserved;
    logic [31:0] data_start;
    logic [31:0] root_sector;
    kind_t       kind;
  } geo_t;

endpackage

`default_nettype wire

// File: hw/rtl/fte_if.sv
// ----------------------------------------------------------------------------
// FAT table entry engine channels
// Request and result channels with a valid/ready transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface fte_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [27:0] cluster;
  logic [27:0] new_value;
  logic [13:0] byte_address;
  logic [7:0]  byte_data;

  modport source (output valid, opcode, cluster, new_value, byte_address, byte_data,
                  input ready);
  modport sink (input valid, opcode, cluster, new_value, byte_address, byte_data,
                output ready);
endinterface

interface fte_out_if;
  logic        valid;
  logic        ready;
  logic [27:0] entry_value;
  logic        end_of_chain;
  logic [31:0] cluster_sector;
  logic [31:0] table_sector;
  logic [11:0] offset_in_sector;
  logic [1:0]  fat_kind;
  logic [31:0] root_sector;
  logic [7:0]  byte_value;
  logic        out_of_range;

  modport source (output valid, entry_value, end_of_chain, cluster_sector, table_sector,
                  offset_in_sector, fat_kind, root_sector, byte_value, out_of_range,
                  input ready);
  modport sink (input valid, entry_value, end_of_chain, cluster_sector, table_sector,
                offset_in_sector, fat_kind, root_sector, byte_value, out_of_range,
                output ready);
endinterface

`default_nettype wire

// File: hw/rtl/fte_geometry.sv
// ----------------------------------------------------------------------------
// FAT table entry engine volume geometry
// Holds the geometry registers and derives region starts and the FAT kind
// through a short register pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fat_table_entry_engine_assert.svh"

module fte_geometry (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire fte_pkg::cfg_idx_t cfg_index,
  input  wire logic [31:0]      cfg_wdata,
  output fte_pkg::geo_t         geo,
  output logic                  geo_ready
);

  logic [3:0]  sector_size_log2_r;
  logic [2:0]  cluster_size_log2_r;
  logic [15:0] reserved_sectors_r;
  logic [2:0]  table_copies_r;
  logic [31:0] sectors_per_table_r;
  logic [15:0] root_entries_r;
  logic [31:0] total_sectors_r;
  logic [27:0] root_cluster_r;

  logic [3:0]                       eff_sl;
  logic [11:0]                      bps_m1;
  logic [21:0]                      root_bytes;
  logic [3:0]                       sector_log2_r;
  logic [31:0]                      prod_r;
  logic [fte_pkg::ROOT_SECS_W-1:0]  root_secs_r;
  logic [31:0]                      rc_off_r;
  logic [31:0]                      root_start_r;
  logic [31:0]                      data_start_r;
  logic [31:0]                      clusters_r;
  fte_pkg::kind_t                   kind_c;
  fte_pkg::kind_t                   kind_r;
  logic [31:0]                      root_sector_r;
  logic [fte_pkg::SETTLE_W-1:0]     settle_r;
  logic [fte_pkg::SETTLE_W-1:0]     settle_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sector_size_log2_r  <= 4'd9;
      cluster_size_log2_r <= 3'd0;
      reserved_sectors_r  <= 16'd1;
      table_copies_r      <= 3'd2;
      sectors_per_table_r <= 32'd9;
      root_entries_r      <= 16'd224;
      total_sectors_r     <= 32'd2880;
      root_cluster_r      <= 28'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        fte_pkg::CFG_SECTOR_SIZE_LOG2:  sector_size_log2_r  <= cfg_wdata[3:0];
        fte_pkg::CFG_CLUSTER_SIZE_LOG2: cluster_size_log2_r <= cfg_wdata[2:0];
        fte_pkg::CFG_RESERVED_SECTORS:  reserved_sectors_r  <= cfg_wdata[15:0];
        fte_pkg::CFG_TABLE_COPIES:      table_copies_r      <= cfg_wdata[2:0];
        fte_pkg::CFG_SECTORS_PER_TABLE: sectors_per_table_r <= cfg_wdata;
        fte_pkg::CFG_ROOT_ENTRIES:      root_entries_r      <= cfg_wdata[15:0];
        fte_pkg::CFG_TOTAL_SECTORS:     total_sectors_r     <= cfg_wdata;
        fte_pkg::CFG_ROOT_CLUSTER:      root_cluster_r      <= cfg_wdata[27:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (sector_size_log2_r < 4'd9) begin
      eff_sl = 4'd9;
    end else if (sector_size_log2_r > 4'd12) begin
      eff_sl = 4'd12;
    end else begin
      eff_sl = sector_size_log2_r;
    end
    bps_m1     = 12'hFFF >> (4'd12 - eff_sl);
    root_bytes = 22'({root_entries_r, 5'b0}) + 22'(bps_m1);
  end

  always_comb begin
    if (clusters_r < fte_pkg::FAT12_LIMIT) begin
      kind_c = fte_pkg::KIND_FAT12;
    end else if (clusters_r < fte_pkg::FAT16_LIMIT) begin
      kind_c = fte_pkg::KIND_FAT16;
    end else begin
      kind_c = fte_pkg::KIND_FAT32;
    end
  end

  always_ff @(posedge clk) begin
    sector_log2_r <= eff_sl;
    prod_r        <= sectors_per_table_r * 32'(table_copies_r);
    root_secs_r   <= fte_pkg::ROOT_SECS_W'(root_bytes >> eff_sl);
    rc_off_r      <= (32'(root_cluster_r) - 32'd2) << cluster_size_log2_r;
    root_start_r  <= 32'(reserved_sectors_r) + prod_r;
    data_start_r  <= root_start_r + 32'(root_secs_r);
    clusters_r    <= (total_sectors_r - data_start_r) >> cluster_size_log2_r;
    kind_r        <= kind_c;
    root_sector_r <= (kind_c == fte_pkg::KIND_FAT32) ? rc_off_r + data_start_r
                                                     : root_start_r;
  end

  always_comb begin
    if (cfg_we) begin
      settle_nxt = fte_pkg::SETTLE_W'(fte_pkg::GEO_SETTLE);
    end else if (settle_r != '0) begin
      settle_nxt = settle_r - 1'b1;
    end else begin
      settle_nxt = settle_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= fte_pkg::SETTLE_W'(fte_pkg::GEO_SETTLE);
    end else begin
      settle_r <= settle_nxt;
    end
  end

  assign geo_ready        = (settle_r == '0);
  assign geo.sector_log2  = sector_log2_r;
  assign geo.cluster_log2 = cluster_size_log2_r;
  assign geo.reserved     = reserved_sectors_r;
  assign geo.data_start   = data_start_r;
  assign geo.root_sector  = root_sector_r;
  assign geo.kind         = kind_r;

  `FTE_ASSERT_NEXT(a_settle_after_cfg, cfg_we, !geo_ready, "geometry ready after a register write")

endmodule

`default_nettype wire

// File: hw/rtl/fte_engine.sv
// ----------------------------------------------------------------------------
// FAT table entry engine datapath
// Table store in four byte lanes, entry read-modify-write and the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fat_table_entry_engine_assert.svh"

module fte_engine (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire fte_pkg::geo_t geo,
  input  wire logic          geo_ready,
  fte_in_if.sink             in_ch,
  fte_out_if.source          out_ch
);

  logic [7:0] table_mem [fte_pkg::LANES][fte_pkg::BANK_DEPTH];

  fte_pkg::state_t state_r;
  fte_pkg::state_t state_nxt;

  logic                       in_fire;
  logic                       advance;
  fte_pkg::op_t               op_in;
  logic                       is_byte_in;
  logic [fte_pkg::OFF_W-1:0]  off_in;
  logic [2:0]                 nb_in;
  logic [fte_pkg::ADDR_W-1:0] base_in;
  logic                       oor_in;
  logic [31:0]                ncs_in;
  logic [fte_pkg::ADDR_W-1:0] lane_byte [fte_pkg::LANES];

  fte_pkg::op_t                op_r;
  logic                        odd_r;
  logic [27:0]                 new_value_r;
  logic [7:0]                  byte_data_r;
  logic [fte_pkg::LANE_W-1:0]  lsb_r;
  logic [fte_pkg::OFF_W-1:0]   off_r;
  logic                        oor_r;
  logic [31:0]                 ncs_r;
  logic [fte_pkg::BANK_AW-1:0] bank_addr_r [fte_pkg::LANES];
  logic [7:0]                  rdata_r [fte_pkg::LANES];

  logic                        is_byte_r;
  logic [31:0]                 word;
  logic [27:0]                 entry;
  logic [31:0]                 new_word;
  logic                        eoc;
  logic [fte_pkg::LANE_W-1:0]  lane_idx [fte_pkg::LANES];
  logic [fte_pkg::LANES-1:0]   lane_we;
  logic [7:0]                  lane_wdata [fte_pkg::LANES];

  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [27:0] out_entry_r;
  logic        out_eoc_r;
  logic [31:0] out_csec_r;
  logic [31:0] out_tsec_r;
  logic [11:0] out_offs_r;
  logic [1:0]  out_kind_r;
  logic [31:0] out_root_r;
  logic [7:0]  out_byte_r;
  logic        out_oor_r;

  assign in_ch.ready = (state_r == fte_pkg::ST_IDLE) && geo_ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign advance     = (state_r == fte_pkg::ST_DATA) && (!out_valid_r || out_ch.ready);

  always_comb begin
    op_in      = fte_pkg::op_t'(in_ch.opcode);
    is_byte_in = (op_in == fte_pkg::OP_LOAD) || (op_in == fte_pkg::OP_READBACK);
    case (geo.kind)
      fte_pkg::KIND_FAT12: off_in = fte_pkg::OFF_W'(in_ch.cluster)
                                  + fte_pkg::OFF_W'(in_ch.cluster >> 1);
      fte_pkg::KIND_FAT16: off_in = fte_pkg::OFF_W'({in_ch.cluster, 1'b0});
      default:             off_in = {in_ch.cluster, 2'b00};
    endcase
    nb_in = (geo.kind == fte_pkg::KIND_FAT32) ? 3'd4 : 3'd2;
    if (is_byte_in) begin
      base_in = fte_pkg::ADDR_W'(in_ch.byte_address);
      oor_in  = 32'(in_ch.byte_address) >= 32'(fte_pkg::TABLE_BYTES);
    end else begin
      base_in = fte_pkg::ADDR_W'(off_in);
      oor_in  = (32'(off_in) + 32'(nb_in)) > 32'(fte_pkg::TABLE_BYTES);
    end
    ncs_in = (32'(in_ch.cluster) - 32'd2) << geo.cluster_log2;
    for (int b = 0; b < fte_pkg::LANES; b++) begin
      lane_byte[b] = base_in
                   + fte_pkg::ADDR_W'(fte_pkg::LANE_W'(fte_pkg::LANE_W'(b)
                                                       - base_in[fte_pkg::LANE_W-1:0]));
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r        <= op_in;
      odd_r       <= in_ch.cluster[0];
      new_value_r <= in_ch.new_value;
      byte_data_r <= in_ch.byte_data;
      lsb_r       <= base_in[fte_pkg::LANE_W-1:0];
      off_r       <= off_in;
      oor_r       <= oor_in;
      ncs_r       <= ncs_in;
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < fte_pkg::LANES; b++) begin
      if (lane_we[b]) begin
        table_mem[b][bank_addr_r[b]] <= lane_wdata[b];
      end
      if (in_fire) begin
        rdata_r[b]     <= table_mem[b][lane_byte[b][fte_pkg::ADDR_W-1:fte_pkg::LANE_W]];
        bank_addr_r[b] <= lane_byte[b][fte_pkg::ADDR_W-1:fte_pkg::LANE_W];
      end
    end
  end

  always_comb begin
    is_byte_r = (op_r == fte_pkg::OP_LOAD) || (op_r == fte_pkg::OP_READBACK);
    for (int i = 0; i < fte_pkg::LANES; i++) begin
      word[8*i +: 8] = rdata_r[fte_pkg::LANE_W'(lsb_r + fte_pkg::LANE_W'(i))];
    end
    case (geo.kind)
      fte_pkg::KIND_FAT12: begin
        entry    = odd_r ? 28'(word[15:4]) : 28'(word[11:0]);
        new_word = odd_r ? {16'b0, new_value_r[11:0], word[3:0]}
                         : {16'b0, word[15:12], new_value_r[11:0]};
        eoc      = entry >= fte_pkg::EOC_FAT12;
      end
      fte_pkg::KIND_FAT16: begin
        entry    = 28'(word[15:0]);
        new_word = {16'b0, new_value_r[15:0]};
        eoc      = entry >= fte_pkg::EOC_FAT16;
      end
      default: begin
        entry    = word[27:0];
        new_word = {word[31:28], new_value_r};
        eoc      = entry >= fte_pkg::EOC_FAT32;
      end
    endcase
    if (oor_r) begin
      entry = '0;
      eoc   = 1'b0;
    end
    for (int l = 0; l < fte_pkg::LANES; l++) begin
      lane_idx[l] = fte_pkg::LANE_W'(fte_pkg::LANE_W'(l) - lsb_r);
      if (op_r == fte_pkg::OP_LOAD) begin
        lane_we[l]    = advance && !oor_r && (lane_idx[l] == '0);
        lane_wdata[l] = byte_data_r;
      end else begin
        lane_we[l]    = advance && !oor_r && (op_r == fte_pkg::OP_WRITE)
                     && ((lane_idx[l] < 2'd2) || (geo.kind == fte_pkg::KIND_FAT32));
        lane_wdata[l] = new_word[8*lane_idx[l] +: 8];
      end
    end
  end

  always_comb begin
    case (state_r)
      fte_pkg::ST_IDLE: state_nxt = in_fire ? fte_pkg::ST_DATA : fte_pkg::ST_IDLE;
      fte_pkg::ST_DATA: state_nxt = advance ? fte_pkg::ST_IDLE : fte_pkg::ST_DATA;
      default:          state_nxt = fte_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fte_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_kind_r <= geo.kind;
      out_root_r <= geo.root_sector;
      out_oor_r  <= oor_r;
      if (is_byte_r) begin
        out_entry_r <= '0;
        out_eoc_r   <= 1'b0;
        out_csec_r  <= '0;
        out_tsec_r  <= '0;
        out_offs_r  <= '0;
        out_byte_r  <= (op_r == fte_pkg::OP_READBACK && !oor_r) ? rdata_r[lsb_r] : 8'd0;
      end else begin
        out_entry_r <= entry;
        out_eoc_r   <= eoc;
        out_csec_r  <= ncs_r + geo.data_start;
        out_tsec_r  <= 32'(geo.reserved) + 32'(off_r >> geo.sector_log2);
        out_offs_r  <= off_r[11:0] & ~(12'hFFF << geo.sector_log2);
        out_byte_r  <= 8'd0;
      end
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.entry_value      = out_entry_r;
  assign out_ch.end_of_chain     = out_eoc_r;
  assign out_ch.cluster_sector   = out_csec_r;
  assign out_ch.table_sector     = out_tsec_r;
  assign out_ch.offset_in_sector = out_offs_r;
  assign out_ch.fat_kind         = out_kind_r;
  assign out_ch.root_sector      = out_root_r;
  assign out_ch.byte_value       = out_byte_r;
  assign out_ch.out_of_range     = out_oor_r;

  `FTE_ASSERT_NOW(a_write_only_in_data, |lane_we, state_r == fte_pkg::ST_DATA, "stray write")
  `FTE_ASSERT_NOW(a_no_write_oor, oor_r && state_r == fte_pkg::ST_DATA, ~|lane_we, "write oor")
  `FTE_ASSERT_NEXT(a_result_after_update, advance, out_valid_r && !state_r, "no result")

endmodule

`default_nettype wire

// File: hw/rtl/fat_table_entry_engine.sv
// ----------------------------------------------------------------------------
// FAT table entry engine
// Every accepted item gives one result: the transfer edge reads all four
// byte lanes of the table memory; in the data state, once the output
// register is free, the block assembles the entry, writes the modified
// bytes back through the single port of each lane and loads the result
// register. The input is ready only while idle, so a new item is taken only
// after the last one has loaded its result; a result waiting in the
// output register holds back only the update of the following item. After
// reset and after every register write the input stays not ready while the
// settle counter runs down and the region starts and the FAT kind are
// recomputed. The table memory is not cleared: entries read before being
// loaded return undefined data.
// ----------------------------------------------------------------------------
`default_nettype none

module fat_table_entry_engine (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire fte_pkg::cfg_idx_t cfg_index,
  input  wire logic [31:0]       cfg_wdata,
  fte_in_if.sink                 in_ch,
  fte_out_if.source              out_ch
);

  fte_pkg::geo_t geo;
  logic          geo_ready;

  fte_geometry u_geometry (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .geo       (geo),
    .geo_ready (geo_ready)
  );

  fte_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .geo       (geo),
    .geo_ready (geo_ready),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// File: test/fat_table_entry_engine_tb.sv
// ----------------------------------------------------------------------------
// FAT table entry engine testbench
// Sends table byte and cluster entry requests through the request channel,
// works out every result from its own copy of the volume registers and of
// the table bytes, and checks the results in order while both channels idle
// at random. Directed cases cover the byte operations, FAT12 packing and the
// FAT kind limits; random traffic follows under several volume settings.
// ----------------------------------------------------------------------------
module fat_table_entry_engine_tb;
  import fte_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned RANDOM_PHASES   = 6;
  localparam int unsigned ITEMS_PER_PHASE = 62;

  typedef struct packed {
    op_t         op;
    logic [27:0] cluster;
    logic [27:0] new_value;
    logic [13:0] byte_address;
    logic [7:0]  byte_data;
  } fat_request_t;

  typedef struct packed {
    logic [27:0] entry_value;
    logic        end_of_chain;
    logic [31:0] cluster_sector;
    logic [31:0] table_sector;
    logic [11:0] offset_in_sector;
    kind_t       fat_kind;
    logic [31:0] root_sector;
    logic [7:0]  byte_value;
    logic        out_of_range;
  } fat_result_t;

  typedef struct packed {
    logic [31:0] sector_log2;
    logic [31:0] data_start;
    logic [31:0] root_sector;
    kind_t       kind;
  } volume_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  cfg_idx_t    cfg_index;
  logic [31:0] cfg_wdata;

  fte_in_if  in_ch ();
  fte_out_if out_ch ();

  fat_table_entry_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  logic [31:0]  volume_regs [8];
  logic [7:0]   table_copy [TABLE_BYTES];
  bit           byte_loaded [TABLE_BYTES];
  int unsigned  loaded_addrs [$];
  fat_result_t  pending_results [$];
  int unsigned  mismatches = 0;
  int unsigned  quiet_cycles = 0;
  bit           sender_idles = 1'b1;
  bit           receiver_idles = 1'b1;

  always #4 clk = ~clk;

  function automatic volume_t derive_volume();
    volume_t     v;
    logic [31:0] bytes_per_sector;
    logic [31:0] root_secs;
    logic [31:0] root_start;
    logic [31:0] clusters;
    if (volume_regs[CFG_SECTOR_SIZE_LOG2] < 32'd9) begin
      v.sector_log2 = 32'd9;
    end else if (volume_regs[CFG_SECTOR_SIZE_LOG2] > 32'd12) begin
      v.sector_log2 = 32'd12;
    end else begin
      v.sector_log2 = volume_regs[CFG_SECTOR_SIZE_LOG2];
    end
    bytes_per_sector = 32'd1 << v.sector_log2;
    root_secs = (volume_regs[CFG_ROOT_ENTRIES] * 32'd32 + bytes_per_sector - 32'd1)
                >> v.sector_log2;
    root_start = volume_regs[CFG_RESERVED_SECTORS]
                 + volume_regs[CFG_TABLE_COPIES] * volume_regs[CFG_SECTORS_PER_TABLE];
    v.data_start = root_start + root_secs;
    clusters = (volume_regs[CFG_TOTAL_SECTORS] - v.data_start)
               >> volume_regs[CFG_CLUSTER_SIZE_LOG2];
    if (clusters < FAT12_LIMIT) begin
      v.kind = KIND_FAT12;
    end else if (clusters < FAT16_LIMIT) begin
      v.kind = KIND_FAT16;
    end else begin
      v.kind = KIND_FAT32;
    end
    if (v.kind == KIND_FAT32) begin
      v.root_sector = ((volume_regs[CFG_ROOT_CLUSTER] - 32'd2)
                       << volume_regs[CFG_CLUSTER_SIZE_LOG2]) + v.data_start;
    end else begin
      v.root_sector = root_start;
    end
    return v;
  endfunction

  function automatic void entry_place(logic [27:0] cluster, kind_t k,
                                      output logic [31:0] off, output int unsigned nb);
    case (k)
      KIND_FAT12: begin
        off = {4'd0, cluster} + {5'd0, cluster[27:1]};
        nb = 2;
      end
      KIND_FAT16: begin
        off = {3'd0, cluster, 1'b0};
        nb = 2;
      end
      default: begin
        off = {2'd0, cluster, 2'b00};
        nb = 4;
      end
    endcase
  endfunction

  // Entries that lie wholly in the store may only be touched once every byte
  // has been loaded; entries beyond the store never read it.
  function automatic bit entry_is_defined(logic [27:0] cluster, kind_t k);
    logic [31:0] off;
    int unsigned nb;
    int unsigned i;
    entry_place(cluster, k, off, nb);
    if (off + nb > TABLE_BYTES) return 1'b1;
    for (i = 0; i < nb; i++) begin
      if (!byte_loaded[off + i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic fat_result_t predict_entry_access(fat_request_t r);
    fat_result_t res;
    volume_t     v;
    logic [31:0] off;
    logic [31:0] word;
    logic [31:0] new_word;
    logic [31:0] n;
    logic [31:0] value;
    int unsigned nb;
    int unsigned i;
    v = derive_volume();
    res = '0;
    res.fat_kind = v.kind;
    res.root_sector = v.root_sector;
    if (r.op == OP_LOAD || r.op == OP_READBACK) begin
      if (32'(r.byte_address) >= TABLE_BYTES) begin
        res.out_of_range = 1'b1;
      end else if (r.op == OP_LOAD) begin
        table_copy[r.byte_address] = r.byte_data;
        if (!byte_loaded[r.byte_address]) begin
          loaded_addrs.insert(loaded_addrs.size(), r.byte_address);
        end
        byte_loaded[r.byte_address] = 1'b1;
      end else begin
        res.byte_value = table_copy[r.byte_address];
      end
    end else begin
      n = {4'd0, r.cluster};
      value = {4'd0, r.new_value};
      entry_place(r.cluster, v.kind, off, nb);
      res.cluster_sector = ((n - 32'd2) << volume_regs[CFG_CLUSTER_SIZE_LOG2]) + v.data_start;
      res.table_sector = volume_regs[CFG_RESERVED_SECTORS] + (off >> v.sector_log2);
      res.offset_in_sector = 12'(off & ((32'd1 << v.sector_log2) - 32'd1));
      if (off + nb > TABLE_BYTES) begin
        res.out_of_range = 1'b1;
      end else begin
        word = '0;
        for (i = 0; i < nb; i++) begin
          word |= {24'd0, table_copy[off + i]} << (8 * i);
        end
        case (v.kind)
          KIND_FAT12: res.entry_value = n[0] ? 28'(word >> 4) : 28'(word & 32'h0FFF);
          KIND_FAT16: res.entry_value = 28'(word & 32'hFFFF);
          default:    res.entry_value = word[27:0];
        endcase
        if (r.op == OP_WRITE) begin
          case (v.kind)
            KIND_FAT12: begin
              if (n[0]) begin
                new_word = ((value & 32'h0FFF) << 4) | (word & 32'h000F);
              end else begin
                new_word = (word & 32'hF000) | (value & 32'h0FFF);
              end
            end
            KIND_FAT16: new_word = value & 32'hFFFF;
            default:    new_word = (word & 32'hF000_0000) | value;
          endcase
          for (i = 0; i < nb; i++) begin
            table_copy[off + i] = new_word[8 * i +: 8];
          end
        end
      end
      case (v.kind)
        KIND_FAT12: res.end_of_chain = res.entry_value >= EOC_FAT12;
        KIND_FAT16: res.end_of_chain = res.entry_value >= EOC_FAT16;
        default:    res.end_of_chain = res.entry_value >= EOC_FAT32;
      endcase
    end
    return res;
  endfunction

  function automatic string describe_result(fat_result_t r);
    return $sformatf({"entry=%h eoc=%b cluster_sec=%h table_sec=%h offset=%h kind=%0d ",
                      "root_sec=%h byte=%h oor=%b"},
                     r.entry_value, r.end_of_chain, r.cluster_sector, r.table_sector,
                     r.offset_in_sector, r.fat_kind, r.root_sector, r.byte_value,
                     r.out_of_range);
  endfunction

  function automatic logic [13:0] hot_byte();
    case ($urandom_range(0, 9))
      0:          return 14'($urandom());
      1, 2, 3, 4: return 14'($urandom_range(0, 63));
      default:    return 14'($urandom_range(TABLE_BYTES - 64, TABLE_BYTES - 1));
    endcase
  endfunction

  function automatic logic [27:0] cluster_at(logic [13:0] t, kind_t k);
    case (k)
      KIND_FAT12: return 28'((32'(t) * 2) / 3);
      KIND_FAT16: return 28'(t >> 1);
      default:    return 28'(t >> 2);
    endcase
  endfunction

  function automatic fat_request_t draw_request(kind_t k);
    fat_request_t r;
    int unsigned  pick;
    r.op = OP_LOAD;
    r.cluster = 28'($urandom());
    r.new_value = 28'($urandom());
    r.byte_address = 14'($urandom());
    r.byte_data = 8'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      r.byte_address = hot_byte();
    end else if (pick < 27 && loaded_addrs.size() != 0) begin
      r.op = OP_READBACK;
      r.byte_address = 14'(loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)]);
    end else begin
      r.op = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
      if ($urandom_range(0, 3) == 0) begin
        case (k)
          KIND_FAT12: r.new_value = EOC_FAT12 - 28'd8 + 28'($urandom_range(0, 15));
          KIND_FAT16: r.new_value = EOC_FAT16 - 28'd8 + 28'($urandom_range(0, 15));
          default:    r.new_value = EOC_FAT32 - 28'd8 + 28'($urandom_range(0, 15));
        endcase
      end
      if (pick < 90) r.cluster = cluster_at(hot_byte(), k);
      if (!entry_is_defined(r.cluster, k)) begin
        r.op = OP_LOAD;
        r.byte_address = hot_byte();
      end
    end
    return r;
  endfunction

  task automatic send_request(fat_request_t r);
    int unsigned gap;
    gap = sender_idles ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= r.op;
    in_ch.cluster <= r.cluster;
    in_ch.new_value <= r.new_value;
    in_ch.byte_address <= r.byte_address;
    in_ch.byte_data <= r.byte_data;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    pending_results.insert(pending_results.size(), predict_entry_access(r));
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_register(cfg_idx_t idx, logic [31:0] value);
    logic [31:0] mask;
    case (idx)
      CFG_SECTOR_SIZE_LOG2:  mask = 32'h0000_000F;
      CFG_CLUSTER_SIZE_LOG2: mask = 32'h0000_0007;
      CFG_RESERVED_SECTORS:  mask = 32'h0000_FFFF;
      CFG_TABLE_COPIES:      mask = 32'h0000_0007;
      CFG_SECTORS_PER_TABLE: mask = 32'hFFFF_FFFF;
      CFG_ROOT_ENTRIES:      mask = 32'h0000_FFFF;
      CFG_TOTAL_SECTORS:     mask = 32'hFFFF_FFFF;
      default:               mask = 32'h0FFF_FFFF;
    endcase
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    volume_regs[idx] = value & mask;
    @(posedge clk);
  endtask

  // The total is chosen last so that the volume holds the given cluster count.
  task automatic set_volume(logic [3:0] sl, logic [2:0] cl, logic [15:0] reserved,
                            logic [2:0] copies, logic [31:0] spt, logic [15:0] roots,
                            logic [27:0] root_cl, logic [31:0] clusters);
    volume_t v;
    wait_idle();
    write_register(CFG_SECTOR_SIZE_LOG2, {28'd0, sl});
    write_register(CFG_CLUSTER_SIZE_LOG2, {29'd0, cl});
    write_register(CFG_RESERVED_SECTORS, {16'd0, reserved});
    write_register(CFG_TABLE_COPIES, {29'd0, copies});
    write_register(CFG_SECTORS_PER_TABLE, spt);
    write_register(CFG_ROOT_ENTRIES, {16'd0, roots});
    write_register(CFG_ROOT_CLUSTER, {4'd0, root_cl});
    v = derive_volume();
    write_register(CFG_TOTAL_SECTORS, v.data_start + (clusters << cl)
                   + ($urandom() & ((32'd1 << cl) - 32'd1)));
    cfg_we <= 1'b0;
  endtask

  task automatic random_volume(kind_t target);
    logic [2:0]  cl;
    logic [31:0] clusters;
    logic [31:0] spt;
    cl = 3'($urandom_range(0, 7));
    case (target)
      KIND_FAT12: clusters = $urandom_range(0, 4084);
      KIND_FAT16: clusters = $urandom_range(4085, 65524);
      default:    clusters = $urandom_range(65525, 32'hFFFF_FFFF >> cl);
    endcase
    spt = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(1, 4096);
    set_volume(4'($urandom_range(0, 15)), cl, 16'($urandom()), 3'($urandom_range(0, 7)),
               spt, 16'($urandom()), 28'($urandom()), clusters);
  endtask

  task automatic fill_bytes(int unsigned lo, int unsigned hi);
    int unsigned a;
    for (a = lo; a <= hi; a++) begin
      send_request('{OP_LOAD, 28'($urandom()), 28'($urandom()), 14'(a), 8'($urandom())});
    end
  endtask

  task automatic test_byte_transfers();
    send_request('{OP_LOAD, 28'd0, 28'd0, 14'h3FFF, 8'hFF});
    send_request('{OP_LOAD, 28'hFFFFFFF, 28'hFFFFFFF, 14'h0000, 8'h00});
    send_request('{OP_READBACK, 28'd0, 28'd0, 14'h3FFF, 8'h00});
    send_request('{OP_READBACK, 28'd5, 28'd5, 14'h0000, 8'hFF});
    fill_bytes(0, 7);
  endtask

  task automatic test_fat12_packing();
    send_request('{OP_WRITE, 28'd2, 28'hFFFFFFF, 14'd0, 8'd0});
    send_request('{OP_WRITE, 28'd3, 28'h0000FF7, 14'd0, 8'd0});
    send_request('{OP_READ, 28'd2, 28'd0, 14'd0, 8'd0});
    send_request('{OP_READ, 28'd3, 28'd0, 14'd0, 8'd0});
    send_request('{OP_READ, 28'd0, 28'd0, 14'd0, 8'd0});
    send_request('{OP_READ, 28'hFFFFFFF, 28'd0, 14'd0, 8'd0});
  endtask

  task automatic test_kind_limits();
    set_volume(4'd0, 3'd0, 16'd1, 3'd2, 32'd9, 16'd224, 28'd2, 32'd4084);
    send_request('{OP_READ, 28'd2, 28'd0, 14'd0, 8'd0});
    set_volume(4'd15, 3'd7, 16'hFFFF, 3'd4, 32'd1000, 16'd0, 28'd0, 32'd4085);
    send_request('{OP_WRITE, 28'd3, 28'hFFFFFFF, 14'd0, 8'd0});
    send_request('{OP_READ, 28'd3, 28'd0, 14'd0, 8'd0});
    set_volume(4'd12, 3'd1, 16'd32, 3'd1, 32'hFFFF_FFFF, 16'hFFFF, 28'hFFFFFFF, 32'd65524);
    send_request('{OP_READ, 28'd1, 28'd0, 14'd0, 8'd0});
    set_volume(4'd9, 3'd0, 16'd0, 3'd0, 32'd0, 16'd0, 28'd1, 32'd65525);
    send_request('{OP_WRITE, 28'd1, 28'hFFFFFFF, 14'd0, 8'd0});
    send_request('{OP_READ, 28'd1, 28'd0, 14'd0, 8'd0});
    // A total below the overhead wraps the cluster count round to FAT32.
    set_volume(4'd10, 3'd0, 16'd64, 3'd2, 32'd100, 16'd512, 28'd2, 32'hFFFF_FFFF);
    send_request('{OP_READ, 28'd0, 28'd0, 14'd0, 8'd0});
  endtask

  task automatic test_random_traffic();
    kind_t       k;
    volume_t     vol;
    int unsigned phase;
    int unsigned i;
    fill_bytes(0, 63);
    fill_bytes(TABLE_BYTES - 64, TABLE_BYTES - 1);
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      sender_idles = (phase != 1) && (phase != 3);
      receiver_idles = (phase != 1) && (phase != 2);
      random_volume(kind_t'(phase % 3));
      vol = derive_volume();
      k = vol.kind;
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (phase == 4 && i == ITEMS_PER_PHASE / 2) wait_idle();
        send_request(draw_request(k));
      end
    end
  endtask

  initial begin
    int unsigned hold;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      hold = receiver_idles ? $urandom_range(0, 13) : 0;
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  always @(posedge clk) begin
    fat_result_t seen;
    fat_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.entry_value = out_ch.entry_value;
      seen.end_of_chain = out_ch.end_of_chain;
      seen.cluster_sector = out_ch.cluster_sector;
      seen.table_sector = out_ch.table_sector;
      seen.offset_in_sector = out_ch.offset_in_sector;
      seen.fat_kind = kind_t'(out_ch.fat_kind);
      seen.root_sector = out_ch.root_sector;
      seen.byte_value = out_ch.byte_value;
      seen.out_of_range = out_ch.out_of_range;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: %s", describe_result(seen));
      end else begin
        want = pending_results.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Result mismatch\n  expected %s\n  actual   %s",
                     describe_result(want), describe_result(seen));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_SECTOR_SIZE_LOG2;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= OP_LOAD;
    in_ch.cluster <= '0;
    in_ch.new_value <= '0;
    in_ch.byte_address <= '0;
    in_ch.byte_data <= '0;
    volume_regs = '{32'd9, 32'd0, 32'd1, 32'd2, 32'd9, 32'd224, 32'd2880, 32'd2};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_byte_transfers();
    test_fat12_packing();
    test_kind_limits();
    test_random_traffic();
    wait_idle();
    repeat (10) @(posedge clk);
    mismatches += pending_results.size();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/fte_pkg.sv
hw/rtl/fte_if.sv
hw/rtl/fte_geometry.sv
hw/rtl/fte_engine.sv
hw/rtl/fat_table_entry_engine.sv
test/fat_table_entry_engine_tb.sv
